FILE: hdl/rwm_pkg.sv
// Shared constants for the modular range wrap block.
// No dependencies; the top level and its checker import this package.
package rwm_pkg;

   localparam int DATA_W     = 64;
   localparam int DIV_STAGES = DATA_W;
   localparam int LATENCY    = DIV_STAGES + 3;

endpackage

FILE: hdl/range_wrap_modulo_u64.sv
// Top level of the modular range wrap block: bound ordering, offset and span,
// a pipelined restoring remainder unit and the final add. Depends on rwm_pkg.
//
// Each beat folds req_value_in into the closed interval between req_bound_a
// and req_bound_b, which may arrive in either order, and returns exactly one
// rsp_wrapped beat. The block takes one beat every clock cycle while
// req_stall is low and returns results in order through its stages:
// one stage orders the bounds, one forms the offset and span, 64 stages each
// retire one remainder bit with a 65-bit compare and subtract, and the output
// register adds the lower bound back. The block keeps no state between
// beats. When a result is held by rsp_stall the whole pipeline holds and
// req_stall is raised in the same cycle.
module range_wrap_modulo_u64 (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [rwm_pkg::DATA_W-1:0]  req_value_in,
   input  logic [rwm_pkg::DATA_W-1:0]  req_bound_a,
   input  logic [rwm_pkg::DATA_W-1:0]  req_bound_b,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rwm_pkg::DATA_W-1:0]  rsp_wrapped
);
   import rwm_pkg::*;

   logic              advance;

   logic              ord_valid_ff;
   logic [DATA_W-1:0] ord_low_ff;
   logic [DATA_W-1:0] ord_high_ff;
   logic [DATA_W-1:0] ord_value_ff;

   logic              div_valid_ff [0:DIV_STAGES];
   logic [DATA_W-1:0] rem_ff       [0:DIV_STAGES];
   logic [DATA_W-1:0] rem_in       [1:DIV_STAGES];
   logic [DATA_W-1:0] low_ff       [0:DIV_STAGES];
   logic [DATA_W-1:0] span_ff      [0:DIV_STAGES-1];
   logic [DATA_W-1:0] dsh_ff       [0:DIV_STAGES-1];

   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_wrapped_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         ord_valid_ff <= 1'b0;
      end else if (advance) begin
         ord_valid_ff <= req_valid;
      end
      if (advance) begin
         if (req_bound_a > req_bound_b) begin
            ord_low_ff  <= req_bound_b;
            ord_high_ff <= req_bound_a;
         end else begin
            ord_low_ff  <= req_bound_a;
            ord_high_ff <= req_bound_b;
         end
         ord_value_ff <= req_value_in;
      end
   end

   // A span that overflows to zero is the full domain: every trial
   // subtraction then succeeds with nothing taken away, so the offset passes.
   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         div_valid_ff[0] <= ord_valid_ff;
      end
      if (advance) begin
         rem_ff[0]  <= '0;
         low_ff[0]  <= ord_low_ff;
         dsh_ff[0]  <= ord_value_ff - ord_low_ff;
         span_ff[0] <= ord_high_ff - ord_low_ff + DATA_W'(1);
      end
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [DATA_W:0] trial;
      logic [DATA_W:0] diff;

      always_comb begin
         trial = {rem_ff[k], dsh_ff[k][DATA_W-1]};
         diff  = trial - {1'b0, span_ff[k]};
         if (!diff[DATA_W]) begin
            rem_in[k+1] = diff[DATA_W-1:0];
         end else begin
            rem_in[k+1] = trial[DATA_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            div_valid_ff[k+1] <= div_valid_ff[k];
         end
         if (advance) begin
            rem_ff[k+1] <= rem_in[k+1];
            low_ff[k+1] <= low_ff[k];
         end
      end

      if (k < DIV_STAGES-1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               span_ff[k+1] <= span_ff[k];
               dsh_ff[k+1]  <= {dsh_ff[k][DATA_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid_ff[DIV_STAGES];
      end
      if (advance) begin
         rsp_wrapped_ff <= low_ff[DIV_STAGES] + rem_ff[DIV_STAGES];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_wrapped = rsp_wrapped_ff;

endmodule

FILE: hdl/rwm_checker.sv
// Port-level checker for the modular range wrap block, bound to its top level.
// Depends on rwm_pkg and on the port list of range_wrap_modulo_u64.
module rwm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic [rwm_pkg::DATA_W-1:0]  req_value_in,
   input logic [rwm_pkg::DATA_W-1:0]  req_bound_a,
   input logic [rwm_pkg::DATA_W-1:0]  req_bound_b,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [rwm_pkg::DATA_W-1:0]  rsp_wrapped
);
   import rwm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_wrapped))
      else $error("Stalled result beat changed or vanished.");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("Request beat taken while the result register is held.");

   a_empty_flows: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("Request stalled while the result register is empty.");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result beat present right after reset.");

endmodule

bind range_wrap_modulo_u64 rwm_checker u_rwm_checker (.*);
